@@ rtl/fqrv_pkg.sv @@
// Package for the FIFO queue with remove by value: codes, payload types and defaults.
package fqrv_pkg;

  // Default sizes of the queue.
  localparam int unsigned DefaultDepth     = 16;
  localparam int unsigned DefaultDataWidth = 32;

  // Fixed field widths of the channels.
  localparam int unsigned FieldWidth = 32;
  localparam int unsigned FillWidth  = 5;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    KIND_ENQ = 2'd0,
    KIND_DEQ = 2'd1,
    KIND_REM = 2'd2,
    KIND_NOP = 2'd3
  } kind_e;

  // Status codes of a result item.
  typedef enum logic [1:0] {
    STATUS_DONE = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  // Input item.
  typedef struct packed {
    logic [1:0]            kind;
    logic [FieldWidth-1:0] value;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [1:0]            status;
    logic [FieldWidth-1:0] taken_value;
    logic [FieldWidth-1:0] head_value;
    logic                  is_empty;
    logic [FillWidth-1:0]  fill_count;
  } out_item_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic fire;   // the step is carried out in this cycle
    logic write;  // enqueue with room left
    logic search; // remove by value
  } cell_ctrl_t;

endpackage

@@ rtl/fqrv_cell.sv @@
// One queue position: holds an entry, compares it with the key and shifts toward the head.
module fqrv_cell #(
  parameter int unsigned DATA_WIDTH = fqrv_pkg::DefaultDataWidth,
  parameter int unsigned CNT_W      = 5,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  fqrv_pkg::cell_ctrl_t  ctrl_i,
  input  logic [DATA_WIDTH-1:0] key_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic                  found_i,
  output logic                  found_o,
  input  logic [DATA_WIDTH-1:0] next_data_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] data_next_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] data_d;
  logic                  occupied;
  logic                  hit;

  // A held entry equal to the key marks itself and every later cell for a shift.
  assign occupied = (MyIdx < count_i);
  assign hit      = ctrl_i.search && occupied && (data_q == key_i);
  assign found_o  = found_i || hit;

  // Shift in the neighbor's entry once a dequeue or a removal lies at or ahead of this cell,
  // or take the new value when this cell is the tail slot.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.fire) begin
      if (found_o) begin
        data_d = next_data_i;
      end else if (ctrl_i.write && (count_i == MyIdx)) begin
        data_d = key_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o      = data_q;
  assign data_next_o = data_d;

endmodule

@@ rtl/fifo_queue_with_remove_by_value.sv @@
// Top level of the FIFO queue with remove by value, built as a row of cells.
//
// Usage: each input transfer on in_data_i carries a kind and a value.
// Enqueue appends the value at the tail, dequeue takes the head, and
// remove-by-value deletes the first entry from the head equal to the value
// and closes the gap. Every input transfer yields exactly one result transfer
// on out_data_o with the status, the removed value, and the head, empty flag
// and fill count as they stand after the step.
// Timing: an accepted item is held in the operation registers; in its step
// every cell compares its entry with the key and the row shifts through the
// one-bit found chain, and the result is then held in the output register.
// A new item is taken once the step is done, while the result may still wait
// in the output register.
// Stall: when out_stall_i holds a result, a following item is taken in but
// its step waits until the output register is free.
// Reset: the fill count clears to zero and the queue reads as empty; the
// entries themselves are not cleared and are never read before written.
module fifo_queue_with_remove_by_value #(
  parameter int unsigned DEPTH      = fqrv_pkg::DefaultDepth,
  parameter int unsigned DATA_WIDTH = fqrv_pkg::DefaultDataWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fqrv_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fqrv_pkg::out_item_t out_data_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CountFull = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CountOne  = CNT_W'(1);

  logic                   busy_q, busy_d;
  logic [1:0]             kind_q;
  logic [DATA_WIDTH-1:0]  key_q;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  fqrv_pkg::out_item_t    out_q, out_d;

  logic                   in_fire;
  logic                   fire;
  fqrv_pkg::cell_ctrl_t   ctrl;
  logic                   found_start;
  logic [DEPTH:0]         found;
  logic [DATA_WIDTH-1:0]  cell_data [DEPTH];
  logic [DATA_WIDTH-1:0]  cell_next [DEPTH];
  logic [1:0]             status_d;
  logic [DATA_WIDTH-1:0]  taken_d;

  // Handshake: one item is held at a time until its step is done.
  assign in_stall_o = busy_q;
  assign in_fire    = in_valid_i && !busy_q;
  assign fire       = busy_q && (!out_valid_q || !out_stall_i);

  // Control broadcast to the row of cells.
  assign ctrl.fire   = fire;
  assign ctrl.write  = (kind_q == fqrv_pkg::KIND_ENQ) && (count_q != CountFull);
  assign ctrl.search = (kind_q == fqrv_pkg::KIND_REM);
  assign found_start = (kind_q == fqrv_pkg::KIND_DEQ);
  assign found[0]    = found_start;

  // Row of cells; the last cell shifts in a don't-care entry past the tail.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] next_data;
    if (g == DEPTH - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_mid
      assign next_data = cell_data[g+1];
    end
    fqrv_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (g)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .key_i       (key_q),
      .count_i     (count_q),
      .found_i     (found[g]),
      .found_o     (found[g+1]),
      .next_data_i (next_data),
      .data_o      (cell_data[g]),
      .data_next_o (cell_next[g])
    );
  end

  // Outcome of the step: status, removed value and new fill count.
  always_comb begin
    status_d = fqrv_pkg::STATUS_DONE;
    taken_d  = '0;
    count_d  = count_q;
    unique case (kind_q)
      fqrv_pkg::KIND_ENQ: begin
        if (count_q == CountFull) begin
          status_d = fqrv_pkg::STATUS_FULL;
        end else begin
          count_d = count_q + CountOne;
        end
      end
      fqrv_pkg::KIND_DEQ: begin
        if (count_q == '0) begin
          status_d = fqrv_pkg::STATUS_MISS;
        end else begin
          taken_d = cell_data[0];
          count_d = count_q - CountOne;
        end
      end
      fqrv_pkg::KIND_REM: begin
        if (found[DEPTH]) begin
          taken_d = key_q;
          count_d = count_q - CountOne;
        end else begin
          status_d = fqrv_pkg::STATUS_MISS;
        end
      end
      default: begin
      end
    endcase
  end

  // Result item as it stands after the step.
  always_comb begin
    out_d             = out_q;
    out_d.status      = status_d;
    out_d.taken_value = fqrv_pkg::FieldWidth'(taken_d);
    out_d.head_value  = (count_d != '0) ? fqrv_pkg::FieldWidth'(cell_next[0]) : '0;
    out_d.is_empty    = (count_d == '0);
    out_d.fill_count  = fqrv_pkg::FillWidth'(count_d);
  end

  // Sequencer and output register state.
  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
    end else if (in_fire) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        count_q <= count_d;
      end
    end
  end

  // Payload registers of the operation and the result.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= in_data_i.kind;
      key_q  <= DATA_WIDTH'(in_data_i.value);
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountFull)
    else $error("fill count beyond depth");

  // An accepted item holds the sequencer busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> busy_q)
    else $error("accepted item not held");

  // A result flags empty exactly when its fill count is zero.
  a_empty_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.is_empty == (out_q.fill_count == '0)))
    else $error("empty flag disagrees with fill count");

  // A step that misses or is dropped leaves the fill count alone.
  a_miss_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (status_d != fqrv_pkg::STATUS_DONE)) |=> $stable(count_q))
    else $error("failed step changed the fill count");
`endif

endmodule
